/* src/pmrt_pkg.sv */
// Package for the page map record table: payload structs, command codes and sequencer states.
package pmrt_pkg;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
  } pmrt_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] mapped_address;
    logic        full_error;
    logic [6:0]  entry_count;
  } pmrt_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } pmrt_state_t;

endpackage

/* src/pmrt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module pmrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/page_map_record_table.sv */
// Page map record table: sequential search, update and append of address pairs.
// Clear and unused commands finish straight from idle, as do record and lookup on an
//   empty table; otherwise these walk the entries, reading then comparing each one.
// The walk uses one read index for both RAMs and one 32-bit comparator; busy is high meanwhile,
//   and the next beat is taken as early as the cycle in which done shows.
// The result is flagged by done, which is high for one cycle; the receiver cannot stall it.
// Reset (rst, synchronous) empties the table at once; the RAM contents are not cleared.
module page_map_record_table
  import pmrt_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  pmrt_in_t  request,
  output logic      done,
  output pmrt_out_t result
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  pmrt_state_t state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic [CW-1:0] count, count_next;
  pmrt_in_t      req, req_next;
  pmrt_in_t      cur;
  pmrt_out_t     result_next;
  logic          done_next;
  logic          finish_miss;

  logic          we_v, we_p;
  logic [IW-1:0] waddr;
  logic [31:0]   v_rdata, p_rdata;

  pmrt_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_virtual_store (
    .clk   (clk),
    .we    (we_v),
    .waddr (waddr),
    .wdata (cur.virtual_address),
    .raddr (idx),
    .rdata (v_rdata)
  );

  pmrt_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_physical_store (
    .clk   (clk),
    .we    (we_p),
    .waddr (waddr),
    .wdata (cur.physical_address),
    .raddr (idx),
    .rdata (p_rdata)
  );

  assign busy = (state != ST_IDLE);
  assign cur  = (state == ST_IDLE) ? request : req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    idx    <= idx_next;
    req    <= req_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    count_next  = count;
    req_next    = req;
    result_next = result;
    done_next   = 1'b0;
    finish_miss = 1'b0;
    we_v        = 1'b0;
    we_p        = 1'b0;
    waddr       = idx;

    case (state)
      ST_IDLE: begin
        if (start) begin
          req_next = request;
          idx_next = '0;
          result_next = '0;
          case (request.command)
            CMD_RECORD, CMD_LOOKUP: begin
              if (count == '0) begin
                finish_miss = 1'b1;
              end else begin
                state_next = ST_READ;
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
              done_next  = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (v_rdata == req.virtual_address) begin
          // first match wins: update in place or report its mapping
          state_next      = ST_IDLE;
          done_next       = 1'b1;
          result_next     = '0;
          result_next.hit = 1'b1;
          if (req.command == CMD_RECORD) begin
            we_p = 1'b1;
          end else begin
            result_next.mapped_address = p_rdata;
          end
        end else if (CW'(idx) + CW'(1) < count) begin
          idx_next   = idx + IW'(1);
          state_next = ST_READ;
        end else begin
          finish_miss = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (finish_miss) begin
      state_next  = ST_IDLE;
      done_next   = 1'b1;
      result_next = '0;
      if (cur.command == CMD_RECORD) begin
        if (count < CW'(MAX_ENTRIES)) begin
          // append the new pair behind the filled entries
          we_v       = 1'b1;
          we_p       = 1'b1;
          waddr      = IW'(count);
          count_next = count + CW'(1);
        end else begin
          result_next.full_error = 1'b1;
        end
      end
    end

    if (done_next) begin
      result_next.entry_count = 7'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("filled count exceeds table size");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    done && result.full_error |-> count == CW'(MAX_ENTRIES) && !result.hit)
    else $error("full error without a full table");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> CW'(idx) < count)
    else $error("compare beyond filled entries");

  a_walk_ends_with_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP && state_next == ST_IDLE |=> done)
    else $error("walk ended without a result");

  a_miss_has_no_mapping: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.mapped_address == 32'd0)
    else $error("mapped address set on a miss");

endmodule
